// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define CHK_IMPLIES(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");

// next-cycle implication
`define CHK_NEXT(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");

`endif

// ===== rtl/lru_pkg.sv =====
// ----------------------------------------------------------------------------
// lru_pkg
// Constants and default types for the LRU page replacement block.
// ----------------------------------------------------------------------------
package lru_pkg;

    localparam int DEF_MAX_FRAMES = 16;
    localparam int DEF_PAGE_BITS  = 16;
    localparam int FRAMES_RESET   = 16;
    localparam int CFG_W          = 5;
    localparam int FRAME_IDX_W    = 4;
    localparam int FAULT_W        = 32;

    localparam int DEF_IDX_W = (DEF_MAX_FRAMES > 1) ? $clog2(DEF_MAX_FRAMES) : 1;

    // search word passed cell to cell
    typedef struct packed {
        logic [DEF_PAGE_BITS-1:0] page;
        logic                     hit;
        logic [DEF_IDX_W-1:0]     hit_idx;
        logic [DEF_IDX_W-1:0]     hit_rank;
        logic                     empty_found;
        logic [DEF_IDX_W-1:0]     empty_idx;
        logic [DEF_IDX_W-1:0]     max_rank;
        logic [DEF_IDX_W-1:0]     max_idx;
        logic [DEF_PAGE_BITS-1:0] max_tag;
    } search_t;

    // update broadcast to all cells
    typedef struct packed {
        logic                     clear;
        logic                     en;
        logic                     miss;
        logic [DEF_IDX_W-1:0]     frame;
        logic [DEF_IDX_W-1:0]     limit;
        logic [DEF_PAGE_BITS-1:0] page;
    } update_t;

endpackage

// ===== rtl/lru_if.sv =====
// ----------------------------------------------------------------------------
// lru_if
// Valid/ready channels for page references and replacement results.
// ----------------------------------------------------------------------------
interface lru_req_if #(
    parameter int PAGE_BITS = lru_pkg::DEF_PAGE_BITS
);
    logic                 valid;
    logic                 ready;
    logic [PAGE_BITS-1:0] page_number;

    modport source (output valid, output page_number, input ready);
    modport sink   (input valid, input page_number, output ready);
endinterface

interface lru_rsp_if #(
    parameter int PAGE_BITS = lru_pkg::DEF_PAGE_BITS
);
    logic                            valid;
    logic                            ready;
    logic                            hit;
    logic [lru_pkg::FRAME_IDX_W-1:0] frame_index;
    logic                            evicted_valid;
    logic [PAGE_BITS-1:0]            evicted_page;
    logic [lru_pkg::FAULT_W-1:0]     fault_total;

    modport source (output valid, output hit, output frame_index, output evicted_valid,
                    output evicted_page, output fault_total, input ready);
    modport sink   (input valid, input hit, input frame_index, input evicted_valid,
                    input evicted_page, input fault_total, output ready);
endinterface

// ===== rtl/lru_cell.sv =====
// ----------------------------------------------------------------------------
// lru_cell
// One frame: tag, valid and rank, plus one stage of the search chain.
// ----------------------------------------------------------------------------
module lru_cell #(
    parameter int  IDX       = 0,
    parameter int  IDX_W     = lru_pkg::DEF_IDX_W,
    parameter int  PAGE_BITS = lru_pkg::DEF_PAGE_BITS,
    parameter type search_t  = lru_pkg::search_t,
    parameter type update_t  = lru_pkg::update_t
) (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_use,
    input  logic    tok_in_valid,
    input  search_t tok_in,
    output logic    tok_out_valid,
    output search_t tok_out,
    input  update_t upd
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

    logic                 valid_reg, valid_next;
    logic [IDX_W-1:0]     rank_reg, rank_next;
    logic [PAGE_BITS-1:0] tag_reg, tag_next;
    logic                 tok_valid_reg;
    search_t              tok_reg, tok_next;

    always_comb
    begin
        tok_next = tok_in;
        if (!tok_in.hit && in_use && valid_reg && (tag_reg == tok_in.page))
        begin
            tok_next.hit      = 1'b1;
            tok_next.hit_idx  = MY_IDX;
            tok_next.hit_rank = rank_reg;
        end
        if (!tok_in.empty_found && in_use && !valid_reg)
        begin
            tok_next.empty_found = 1'b1;
            tok_next.empty_idx   = MY_IDX;
        end
        // frame 0 is the victim when no rank exceeds zero
        if (in_use && ((rank_reg > tok_in.max_rank) || (IDX == 0)))
        begin
            tok_next.max_rank = rank_reg;
            tok_next.max_idx  = MY_IDX;
            tok_next.max_tag  = tag_reg;
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        rank_next  = rank_reg;
        tag_next   = tag_reg;
        if (upd.clear)
        begin
            valid_next = 1'b0;
            rank_next  = '0;
        end
        else if (upd.en)
        begin
            if (upd.frame == MY_IDX)
            begin
                valid_next = 1'b1;
                rank_next  = '0;
                if (upd.miss)
                begin
                    tag_next = upd.page;
                end
            end
            else if (in_use && valid_reg && (upd.miss || (rank_reg < upd.limit)))
            begin
                rank_next = rank_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= 1'b0;
            rank_reg      <= '0;
            tok_valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg     <= valid_next;
            rank_reg      <= rank_next;
            tok_valid_reg <= tok_in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        tag_reg <= tag_next;
        if (tok_in_valid)
        begin
            tok_reg <= tok_next;
        end
    end

    assign tok_out_valid = tok_valid_reg;
    assign tok_out       = tok_reg;

endmodule

// ===== rtl/lru_page_replacement.sv =====
// ----------------------------------------------------------------------------
// lru_page_replacement
// Fully associative LRU frame set built as a chain of frame cells.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one page_number per word; rsp returns one word per request
//   with hit, frame_index, evicted_valid, evicted_page and fault_total.
//   A request enters cell 0 and its search word moves one cell per cycle
//   down the MAX_FRAMES cells, collecting the first hit, the first empty
//   frame and the oldest frame. At the end of the chain the decision is
//   broadcast to every cell and the result is registered.
//   One request is in flight at a time; req.ready returns together with
//   rsp.valid, so a new request is not taken before the last one has
//   passed the cell chain and its result is registered.
//   A stalled rsp holds its word; a finished search then waits and req stays
//   not ready until the output register frees.
//   Reset empties all frames, clears the fault count and sets frames_in_use
//   to 16 (at most MAX_FRAMES). cfg_we with cfg_wdata sets frames_in_use
//   (0 taken as 1, clamped to MAX_FRAMES) and clears frames and fault count;
//   write it only while idle.
// ----------------------------------------------------------------------------
module lru_page_replacement #(
    parameter int MAX_FRAMES = lru_pkg::DEF_MAX_FRAMES,
    parameter int PAGE_BITS  = lru_pkg::DEF_PAGE_BITS
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [lru_pkg::CFG_W-1:0] cfg_wdata,
    lru_req_if.sink                   req,
    lru_rsp_if.source                 rsp
);

    localparam int IDX_W   = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int CNT_W   = $clog2(MAX_FRAMES + 1);
    localparam int CLAMP_W = lru_pkg::CFG_W + 2;
    localparam int FRAMES_INIT = (lru_pkg::FRAMES_RESET > MAX_FRAMES) ?
                                 MAX_FRAMES : lru_pkg::FRAMES_RESET;

    typedef struct packed {
        logic [PAGE_BITS-1:0] page;
        logic                 hit;
        logic [IDX_W-1:0]     hit_idx;
        logic [IDX_W-1:0]     hit_rank;
        logic                 empty_found;
        logic [IDX_W-1:0]     empty_idx;
        logic [IDX_W-1:0]     max_rank;
        logic [IDX_W-1:0]     max_idx;
        logic [PAGE_BITS-1:0] max_tag;
    } search_t;

    typedef struct packed {
        logic                 clear;
        logic                 en;
        logic                 miss;
        logic [IDX_W-1:0]     frame;
        logic [IDX_W-1:0]     limit;
        logic [PAGE_BITS-1:0] page;
    } update_t;

    logic [CNT_W-1:0]   frames_reg, frames_next;
    logic [CLAMP_W-1:0] cfg_frames;
    logic               busy_reg;
    logic               fin_valid_reg;
    search_t            fin_reg;
    logic               out_valid_reg;
    logic               out_hit_reg;
    logic [IDX_W-1:0]   out_frame_reg;
    logic               out_ev_valid_reg;
    logic [PAGE_BITS-1:0] out_ev_page_reg;
    logic [lru_pkg::FAULT_W-1:0] fault_reg, fault_next;

    logic               accept;
    logic               do_upd;
    logic [IDX_W-1:0]   dec_frame;
    logic               dec_ev_valid;
    update_t            upd;
    logic [MAX_FRAMES-1:0] in_use;
    logic    tok_valid [MAX_FRAMES+1];
    search_t tok       [MAX_FRAMES+1];

    assign accept    = req.valid && req.ready;
    assign req.ready = !busy_reg;
    assign do_upd    = fin_valid_reg && (!out_valid_reg || rsp.ready);

    always_comb
    begin
        cfg_frames = {2'b00, cfg_wdata};
        if (cfg_wdata == '0)
        begin
            cfg_frames = CLAMP_W'(1);
        end
        if (cfg_frames > CLAMP_W'(MAX_FRAMES))
        begin
            cfg_frames = CLAMP_W'(MAX_FRAMES);
        end
        frames_next = cfg_we ? CNT_W'(cfg_frames) : frames_reg;
    end

    always_comb
    begin
        tok_valid[0]         = accept;
        tok[0]               = '0;
        tok[0].page          = req.page_number;
    end

    genvar g;
    generate
        for (g = 0; g < MAX_FRAMES; g++)
        begin : g_cell
            assign in_use[g] = (CNT_W'(g) < frames_reg);
            lru_cell #(
                .IDX       (g),
                .IDX_W     (IDX_W),
                .PAGE_BITS (PAGE_BITS),
                .search_t  (search_t),
                .update_t  (update_t)
            ) u_cell (
                .clk           (clk),
                .rst_n         (rst_n),
                .in_use        (in_use[g]),
                .tok_in_valid  (tok_valid[g]),
                .tok_in        (tok[g]),
                .tok_out_valid (tok_valid[g+1]),
                .tok_out       (tok[g+1]),
                .upd           (upd)
            );
        end
    endgenerate

    always_comb
    begin
        if (fin_reg.hit)
        begin
            dec_frame = fin_reg.hit_idx;
        end
        else if (fin_reg.empty_found)
        begin
            dec_frame = fin_reg.empty_idx;
        end
        else
        begin
            dec_frame = fin_reg.max_idx;
        end
        dec_ev_valid = !fin_reg.hit && !fin_reg.empty_found;

        upd.clear = cfg_we;
        upd.en    = do_upd;
        upd.miss  = !fin_reg.hit;
        upd.frame = dec_frame;
        upd.limit = fin_reg.hit_rank;
        upd.page  = fin_reg.page;

        fault_next = fault_reg;
        if (cfg_we)
        begin
            fault_next = '0;
        end
        else if (do_upd && !fin_reg.hit && (fault_reg != '1))
        begin
            fault_next = fault_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frames_reg    <= CNT_W'(FRAMES_INIT);
            busy_reg      <= 1'b0;
            fin_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            fault_reg     <= '0;
        end
        else
        begin
            frames_reg <= frames_next;
            fault_reg  <= fault_next;
            if (accept)
            begin
                busy_reg <= 1'b1;
            end
            else if (do_upd)
            begin
                busy_reg <= 1'b0;
            end
            if (tok_valid[MAX_FRAMES])
            begin
                fin_valid_reg <= 1'b1;
            end
            else if (do_upd)
            begin
                fin_valid_reg <= 1'b0;
            end
            if (do_upd)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (tok_valid[MAX_FRAMES])
        begin
            fin_reg <= tok[MAX_FRAMES];
        end
        if (do_upd)
        begin
            out_hit_reg      <= fin_reg.hit;
            out_frame_reg    <= dec_frame;
            out_ev_valid_reg <= dec_ev_valid;
            out_ev_page_reg  <= dec_ev_valid ? fin_reg.max_tag : '0;
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.hit           = out_hit_reg;
    assign rsp.frame_index   = lru_pkg::FRAME_IDX_W'(out_frame_reg);
    assign rsp.evicted_valid = out_ev_valid_reg;
    assign rsp.evicted_page  = out_ev_page_reg;
    assign rsp.fault_total   = fault_reg;

endmodule

// ===== rtl/lru_checker.sv =====
// ----------------------------------------------------------------------------
// lru_checker
// Port-level checks for the LRU page replacement block.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lru_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        req_valid,
    input logic        req_ready,
    input logic        rsp_valid,
    input logic        rsp_ready,
    input logic        rsp_hit,
    input logic        rsp_evicted_valid,
    input logic        rsp_evicted_page_nz,
    input logic        rsp_fault_nz
);

    `CHK_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready, rsp_valid)
    `CHK_NEXT(a_one_in_flight, clk, rst_n, req_valid && req_ready, !req_ready)
    `CHK_IMPLIES(a_hit_no_evict, clk, rst_n, rsp_valid && rsp_hit, !rsp_evicted_valid)
    `CHK_IMPLIES(a_evict_page, clk, rst_n, rsp_valid && !rsp_evicted_valid,
                 !rsp_evicted_page_nz)
    `CHK_IMPLIES(a_fault_count, clk, rst_n, rsp_valid && !rsp_hit, rsp_fault_nz)

endmodule

bind lru_page_replacement lru_checker u_lru_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .req_valid           (req.valid),
    .req_ready           (req.ready),
    .rsp_valid           (rsp.valid),
    .rsp_ready           (rsp.ready),
    .rsp_hit             (rsp.hit),
    .rsp_evicted_valid   (rsp.evicted_valid),
    .rsp_evicted_page_nz (|rsp.evicted_page),
    .rsp_fault_nz        (|rsp.fault_total)
);

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for lru_page_replacement. A directed table covers the
// frame-count clamps, hits, fills and LRU eviction. Random phases follow,
// each with its own frame count and a small page pool so that hits and
// evictions are common. Every result word is checked against its table entry
// or an LRU predictor while both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb;

    localparam int  MAX_FRAMES = lru_pkg::DEF_MAX_FRAMES;
    localparam int  RAND_ITEMS = 1350;
    localparam int  CYCLE_LIMIT = 600000;
    localparam int  POOL_MAX = MAX_FRAMES + 4;
    localparam int  N_DIR = 27;

    typedef struct packed {
        logic                            hit;
        logic [lru_pkg::FRAME_IDX_W-1:0] frame;
        logic                            ev_valid;
        logic [15:0]                     ev_page;
        logic [lru_pkg::FAULT_W-1:0]     faults;
    } lru_result_t;

    typedef enum bit {ROW_PAGE, ROW_CFG} row_kind_t;

    typedef struct packed {
        row_kind_t   kind;
        logic [15:0] value;
        bit          typed;
        lru_result_t want;
    } stim_row_t;

    localparam lru_result_t NO_RES = '0;

    // typed rows carry {hit, frame, evicted_valid, evicted_page, fault_total}
    stim_row_t dir_rows [N_DIR] = '{
        '{ROW_PAGE, 16'h0000, 1'b1, '{1'b0, 4'd0, 1'b0, 16'h0000, 32'd1}},
        '{ROW_PAGE, 16'h0000, 1'b1, '{1'b1, 4'd0, 1'b0, 16'h0000, 32'd1}},
        '{ROW_PAGE, 16'hFFFF, 1'b1, '{1'b0, 4'd1, 1'b0, 16'h0000, 32'd2}},
        '{ROW_PAGE, 16'hFFFF, 1'b1, '{1'b1, 4'd1, 1'b0, 16'h0000, 32'd2}},
        '{ROW_CFG,  16'd0,    1'b0, NO_RES},
        '{ROW_PAGE, 16'h0005, 1'b1, '{1'b0, 4'd0, 1'b0, 16'h0000, 32'd1}},
        '{ROW_PAGE, 16'h0006, 1'b1, '{1'b0, 4'd0, 1'b1, 16'h0005, 32'd2}},
        '{ROW_PAGE, 16'h0006, 1'b1, '{1'b1, 4'd0, 1'b0, 16'h0000, 32'd2}},
        '{ROW_CFG,  16'd31,   1'b0, NO_RES},
        '{ROW_PAGE, 16'hAAAA, 1'b1, '{1'b0, 4'd0, 1'b0, 16'h0000, 32'd1}},
        '{ROW_PAGE, 16'h5555, 1'b1, '{1'b0, 4'd1, 1'b0, 16'h0000, 32'd2}},
        '{ROW_CFG,  16'd2,    1'b0, NO_RES},
        '{ROW_PAGE, 16'h0001, 1'b1, '{1'b0, 4'd0, 1'b0, 16'h0000, 32'd1}},
        '{ROW_PAGE, 16'h0002, 1'b1, '{1'b0, 4'd1, 1'b0, 16'h0000, 32'd2}},
        '{ROW_PAGE, 16'h0001, 1'b1, '{1'b1, 4'd0, 1'b0, 16'h0000, 32'd2}},
        '{ROW_PAGE, 16'h0003, 1'b1, '{1'b0, 4'd1, 1'b1, 16'h0002, 32'd3}},
        '{ROW_PAGE, 16'h0001, 1'b1, '{1'b1, 4'd0, 1'b0, 16'h0000, 32'd3}},
        '{ROW_CFG,  16'd17,   1'b0, NO_RES},
        '{ROW_PAGE, 16'h8000, 1'b0, NO_RES},
        '{ROW_PAGE, 16'h7FFF, 1'b0, NO_RES},
        '{ROW_CFG,  16'd3,    1'b0, NO_RES},
        '{ROW_PAGE, 16'h0010, 1'b0, NO_RES},
        '{ROW_PAGE, 16'h0020, 1'b0, NO_RES},
        '{ROW_PAGE, 16'h0030, 1'b0, NO_RES},
        '{ROW_PAGE, 16'h0020, 1'b0, NO_RES},
        '{ROW_PAGE, 16'h0040, 1'b0, NO_RES},
        '{ROW_PAGE, 16'h0010, 1'b0, NO_RES}
    };

    logic                      clk;
    logic                      rst_n;
    logic                      cfg_we;
    logic [lru_pkg::CFG_W-1:0] cfg_wdata;

    lru_req_if req_ch ();
    lru_rsp_if rsp_ch ();

    lru_page_replacement i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req       (req_ch),
        .rsp       (rsp_ch)
    );

    // predictor state
    logic [15:0]                 m_tag   [MAX_FRAMES];
    bit                          m_valid [MAX_FRAMES];
    int                          m_rank  [MAX_FRAMES];
    logic [lru_pkg::FAULT_W-1:0] m_faults;
    int                          m_frames;

    lru_result_t pending_results [$];
    lru_result_t head_word;
    int          n_errors = 0;
    int          cycle_cnt = 0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic void clear_frames();
        int k;
        for (k = 0; k < MAX_FRAMES; k++)
        begin
            m_tag[k]   = '0;
            m_valid[k] = 1'b0;
            m_rank[k]  = 0;
        end
        m_faults = '0;
    endfunction

    function automatic void load_frame_count(input logic [lru_pkg::CFG_W-1:0] v);
        int n;
        n = int'(v);
        if (n == 0)
            n = 1;
        if (n > MAX_FRAMES)
            n = MAX_FRAMES;
        m_frames = n;
        clear_frames();
    endfunction

    // age valid frames ranked below limit, frame f becomes newest
    function automatic void age_frames(input int f, input int limit);
        int k;
        for (k = 0; k < m_frames; k++)
            if (k != f && m_valid[k] && m_rank[k] < limit)
                m_rank[k]++;
        m_rank[f] = 0;
    endfunction

    function automatic lru_result_t lookup_page(input logic [15:0] page);
        lru_result_t r;
        int          k;
        int          f;
        int          oldest;
        bit          hit;
        bit          found;
        r     = '0;
        f     = 0;
        hit   = 1'b0;
        found = 1'b0;
        for (k = 0; k < m_frames; k++)
            if (!hit && m_valid[k] && m_tag[k] == page)
            begin
                f   = k;
                hit = 1'b1;
            end
        if (hit)
            age_frames(f, m_rank[f]);
        else
        begin
            for (k = 0; k < m_frames; k++)
                if (!found && !m_valid[k])
                begin
                    f     = k;
                    found = 1'b1;
                end
            if (!found)
            begin
                oldest = 0;
                f      = 0;
                for (k = 0; k < m_frames; k++)
                    if (m_rank[k] > oldest)
                    begin
                        oldest = m_rank[k];
                        f      = k;
                    end
                r.ev_valid = 1'b1;
                r.ev_page  = m_tag[f];
            end
            m_tag[f]   = page;
            m_valid[f] = 1'b1;
            age_frames(f, MAX_FRAMES);
            if (m_faults != '1)
                m_faults++;
        end
        r.hit    = hit;
        r.frame  = f[lru_pkg::FRAME_IDX_W-1:0];
        r.faults = m_faults;
        return r;
    endfunction

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %0h expected %0h (cycle %0d)",
                 field, got, want, cycle_cnt);
        n_errors++;
    endtask

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_word(input logic [15:0] page, input bit typed,
                             input lru_result_t want);
        lru_result_t pred;
        req_ch.valid       <= 1'b1;
        req_ch.page_number <= page;
        do
            @(posedge clk);
        while (!req_ch.ready);
        pred = lookup_page(page);
        pending_results.push_back(typed ? want : pred);
        @(negedge clk);
    endtask

    task automatic idle_for(input int n);
        req_ch.valid <= 1'b0;
        repeat (n) @(negedge clk);
    endtask

    task automatic write_frames(input logic [lru_pkg::CFG_W-1:0] v);
        req_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_we    <= 1'b0;
        load_frame_count(v);
    endtask

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (pending_results.size() == 0)
                report_mismatch("unexpected word", rsp_ch.fault_total, 0);
            else
            begin
                head_word = pending_results.pop_front();
                if (rsp_ch.hit !== head_word.hit)
                    report_mismatch("hit", rsp_ch.hit, head_word.hit);
                if (rsp_ch.frame_index !== head_word.frame)
                    report_mismatch("frame_index", rsp_ch.frame_index, head_word.frame);
                if (rsp_ch.evicted_valid !== head_word.ev_valid)
                    report_mismatch("evicted_valid", rsp_ch.evicted_valid,
                                    head_word.ev_valid);
                if (rsp_ch.evicted_page !== head_word.ev_page)
                    report_mismatch("evicted_page", rsp_ch.evicted_page,
                                    head_word.ev_page);
                if (rsp_ch.fault_total !== head_word.faults)
                    report_mismatch("fault_total", rsp_ch.fault_total, head_word.faults);
            end
        end
    end

    // receiver: alternating stall patterns, some fully open
    initial
    begin
        int mode_len;
        int stall_pct;
        rsp_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            mode_len = $urandom_range(20, 200);
            case ($urandom_range(0, 3))
                0: stall_pct = 0;
                1: stall_pct = 25;
                2: stall_pct = 50;
                default: stall_pct = 80;
            endcase
            repeat (mode_len)
            begin
                @(negedge clk);
                rsp_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    initial
    begin
        int                        i;
        int                        n_sent;
        int                        pool_size;
        int                        n_phase;
        int                        burst;
        bit                        quiet;
        logic [15:0]               pool [POOL_MAX];
        logic [15:0]               pg;
        logic [lru_pkg::CFG_W-1:0] fval;

        rst_n              = 1'b0;
        cfg_we             = 1'b0;
        cfg_wdata          = '0;
        req_ch.valid       = 1'b0;
        req_ch.page_number = '0;
        m_frames           = lru_pkg::FRAMES_RESET;
        clear_frames();

        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (i = 0; i < N_DIR; i++)
        begin
            if (dir_rows[i].kind == ROW_CFG)
                write_frames(dir_rows[i].value[lru_pkg::CFG_W-1:0]);
            else
                send_word(dir_rows[i].value, dir_rows[i].typed, dir_rows[i].want);
        end

        n_sent = 0;
        while (n_sent < RAND_ITEMS)
        begin
            case ($urandom_range(0, 9))
                0: fval = lru_pkg::CFG_W'(0);
                1: fval = lru_pkg::CFG_W'(1);
                2: fval = lru_pkg::CFG_W'(16);
                3: fval = lru_pkg::CFG_W'($urandom_range(17, 31));
                default: fval = lru_pkg::CFG_W'($urandom_range(1, 16));
            endcase
            write_frames(fval);
            pool_size = m_frames + $urandom_range(0, 4);
            for (i = 0; i < pool_size; i++)
                pool[i] = 16'($urandom_range(0, 65535));
            quiet   = ($urandom_range(0, 3) == 0);
            n_phase = $urandom_range(60, 160);
            if (n_phase > RAND_ITEMS - n_sent)
                n_phase = RAND_ITEMS - n_sent;
            while (n_phase > 0)
            begin
                burst = $urandom_range(1, 12);
                while (burst > 0 && n_phase > 0)
                begin
                    if ($urandom_range(0, 99) < 85)
                        pg = pool[$urandom_range(0, pool_size - 1)];
                    else
                        pg = 16'($urandom_range(0, 65535));
                    send_word(pg, 1'b0, NO_RES);
                    n_sent++;
                    n_phase--;
                    burst--;
                end
                if (!quiet)
                    idle_for($urandom_range(1, 25));
            end
        end

        req_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (25) @(negedge clk);
        if (n_errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/lru_pkg.sv
rtl/lru_if.sv
rtl/lru_cell.sv
rtl/lru_page_replacement.sv
rtl/lru_checker.sv
tb/sv/tb.sv
